// ----- rtl/vsrl_pkg.sv -----
package vsrl_pkg;

    // Quotient bits produced by the divider; larger limits saturate.
    localparam int QUO_BITS  = 18;
    localparam int DIVR_W    = 18;
    localparam int PROD_W    = 56;
    localparam int LIM_W     = 20;
    localparam int CNT_W     = 5;

    localparam logic [15:0] TICK_RATE_RST = 16'd1000;

    typedef enum logic [2:0] {
        REG_TICK_RATE = 3'd0,
        REG_MIN_VEL   = 3'd1,
        REG_MAX_VEL   = 3'd2,
        REG_MIN_ACCEL = 3'd3,
        REG_MAX_ACCEL = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_LIMIT,
        ST_STEP,
        ST_CLAMP
    } state_t;

endpackage

// ----- rtl/velocity_slew_rate_limiter_unit.sv -----
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata: target_velocity, now_tick
// m_       out  m_tvalid/m_tready  m_tdata: limited_velocity; m_tuser: primed
// cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// A priming transaction passes through the prime state, which loads its result once the output is free.
// Any other transaction runs, for each of the two limits, one multiply, an
// overflow check and an 18-step shift-subtract divide (the divide is skipped
// when the limit saturates), then step and clamp.
// s_tready is high only while idle; a result waits in the output register
// under back-pressure while the next transaction is accepted.
// aresetn is synchronous; it restores register defaults and clears priming.
module velocity_slew_rate_limiter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] target_velocity, [47:16] now_tick
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] limited_velocity
    output logic        m_tuser,   // [0] primed
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int QB = vsrl_pkg::QUO_BITS;
    localparam int DW = vsrl_pkg::DIVR_W;
    localparam int PW = vsrl_pkg::PROD_W;
    localparam int LW = vsrl_pkg::LIM_W;
    localparam int CW = vsrl_pkg::CNT_W;

    vsrl_pkg::state_t state_reg, state_next;

    logic [15:0]        tick_rate_reg;
    logic signed [15:0] min_vel_reg, max_vel_reg;
    logic signed [23:0] min_acc_reg, max_acc_reg;

    logic               primed_reg;
    logic signed [15:0] last_vel_reg;
    logic [31:0]        last_tick_reg;
    logic signed [15:0] target_reg;
    logic [31:0]        elapsed_reg;
    logic               pass_reg;
    logic [PW-1:0]      prod_reg;
    logic               neg_reg;
    logic               ovf_reg;
    logic [DW+QB-1:0]   dq_reg;
    logic [CW-1:0]      cnt_reg;
    logic signed [LW-1:0] lo_reg, hi_reg;
    logic signed [20:0] vsum_reg;

    logic               out_valid_reg;
    logic [15:0]        out_vel_reg;
    logic               out_primed_reg;

    logic               in_fire;
    logic               slot_free;
    logic               use_min;
    logic signed [23:0] acc_sel;
    logic [23:0]        acc_mag;
    logic [PW-1:0]      prod_next;
    logic [15:0]        rate_eff;
    logic [DW-1:0]      divisor;
    logic               ovf_next;
    logic [DW:0]        trial;
    logic               trial_geq;
    logic [DW:0]        trial_diff;
    logic [DW+QB-1:0]   dq_next;
    logic [QB:0]        lim_mag;
    logic signed [LW-1:0] lim_val;
    logic signed [16:0] delta;
    logic signed [LW-1:0] delta_ext, lo_cut, step_val;
    logic signed [20:0] vsum_next;
    logic signed [20:0] vmin_ext, vmax_ext, vlo_cut, vclamped;

    assign in_fire   = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_vel_reg;
    assign m_tuser  = out_primed_reg;

    // Pick the acceleration for this pass and flip per direction of travel
    assign use_min = ~(pass_reg ^ last_vel_reg[15]);
    assign acc_sel = use_min ? min_acc_reg : max_acc_reg;
    assign acc_mag = acc_sel[23] ? 24'(-acc_sel) : 24'(acc_sel);
    assign prod_next = {32'd0, acc_mag} * {24'd0, elapsed_reg};

    // Divisor is the tick rate (a zero rate counts as one), doubled while moving in reverse
    assign rate_eff = (tick_rate_reg == 16'd0) ? 16'd1 : tick_rate_reg;
    assign divisor  = last_vel_reg[15] ? {1'b0, rate_eff, 1'b0} : {2'b00, rate_eff};
    assign ovf_next = prod_reg[PW-1:QB] >= {{(PW-QB-DW){1'b0}}, divisor};

    // One restoring shift-subtract step
    assign trial      = dq_reg[DW+QB-1:QB-1];
    assign trial_geq  = trial >= {1'b0, divisor};
    assign trial_diff = trial - {1'b0, divisor};
    assign dq_next    = {trial_geq ? trial_diff[DW-1:0] : trial[DW-1:0],
                         dq_reg[QB-2:0], trial_geq};

    // Signed limit, saturated just past any reachable velocity step
    assign lim_mag = ovf_reg ? {1'b1, {QB{1'b0}}} : {1'b0, dq_reg[QB-1:0]};
    assign lim_val = neg_reg ? -$signed({1'b0, lim_mag}) : $signed({1'b0, lim_mag});

    // Rate-limit the step
    assign delta     = {target_reg[15], target_reg} - {last_vel_reg[15], last_vel_reg};
    assign delta_ext = {{(LW-17){delta[16]}}, delta};
    assign lo_cut    = (delta_ext > lo_reg) ? delta_ext : lo_reg;
    assign step_val  = (lo_cut < hi_reg) ? lo_cut : hi_reg;
    assign vsum_next = {{5{last_vel_reg[15]}}, last_vel_reg} + {step_val[LW-1], step_val};

    // Clamp to the velocity window; the result always fits 16 bits
    assign vmin_ext = {{5{min_vel_reg[15]}}, min_vel_reg};
    assign vmax_ext = {{5{max_vel_reg[15]}}, max_vel_reg};
    assign vlo_cut  = (vsum_reg > vmin_ext) ? vsum_reg : vmin_ext;
    assign vclamped = (vlo_cut < vmax_ext) ? vlo_cut : vmax_ext;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vsrl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and handshake
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            vsrl_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = primed_reg ? vsrl_pkg::ST_MUL : vsrl_pkg::ST_PRIME;
                end
            end
            vsrl_pkg::ST_PRIME: begin
                if (slot_free) begin
                    state_next = vsrl_pkg::ST_IDLE;
                end
            end
            vsrl_pkg::ST_MUL: begin
                state_next = vsrl_pkg::ST_CHECK;
            end
            vsrl_pkg::ST_CHECK: begin
                state_next = ovf_next ? vsrl_pkg::ST_LIMIT : vsrl_pkg::ST_DIV;
            end
            vsrl_pkg::ST_DIV: begin
                if (cnt_reg == CW'(QB - 1)) begin
                    state_next = vsrl_pkg::ST_LIMIT;
                end
            end
            vsrl_pkg::ST_LIMIT: begin
                state_next = pass_reg ? vsrl_pkg::ST_STEP : vsrl_pkg::ST_MUL;
            end
            vsrl_pkg::ST_STEP: begin
                state_next = vsrl_pkg::ST_CLAMP;
            end
            vsrl_pkg::ST_CLAMP: begin
                if (slot_free) begin
                    state_next = vsrl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vsrl_pkg::ST_IDLE;
            end
        endcase
    end

    // Configuration registers and persistent state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_rate_reg <= vsrl_pkg::TICK_RATE_RST;
            min_vel_reg   <= '0;
            max_vel_reg   <= '0;
            min_acc_reg   <= '0;
            max_acc_reg   <= '0;
            primed_reg    <= 1'b0;
            last_vel_reg  <= '0;
            last_tick_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    vsrl_pkg::REG_TICK_RATE: tick_rate_reg <= cfg_data[15:0];
                    vsrl_pkg::REG_MIN_VEL:   min_vel_reg   <= cfg_data[15:0];
                    vsrl_pkg::REG_MAX_VEL:   max_vel_reg   <= cfg_data[15:0];
                    vsrl_pkg::REG_MIN_ACCEL: min_acc_reg   <= cfg_data;
                    vsrl_pkg::REG_MAX_ACCEL: max_acc_reg   <= cfg_data;
                    default: ;
                endcase
            end
            // Capture the tick; a priming transaction also takes its velocity
            if (in_fire) begin
                last_tick_reg <= s_tdata[47:16];
                if (!primed_reg) begin
                    last_vel_reg <= s_tdata[15:0];
                    primed_reg   <= 1'b1;
                end
            end
            if (state_reg == vsrl_pkg::ST_CLAMP && slot_free) begin
                last_vel_reg <= vclamped[15:0];
            end
            // Output register valid
            if ((state_reg == vsrl_pkg::ST_CLAMP || state_reg == vsrl_pkg::ST_PRIME)
                && slot_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            vsrl_pkg::ST_IDLE: begin
                target_reg  <= s_tdata[15:0];
                elapsed_reg <= s_tdata[47:16] - last_tick_reg;
                pass_reg    <= 1'b0;
            end
            vsrl_pkg::ST_PRIME: begin
                if (slot_free) begin
                    out_vel_reg    <= '0;
                    out_primed_reg <= 1'b0;
                end
            end
            vsrl_pkg::ST_MUL: begin
                prod_reg <= prod_next;
                neg_reg  <= acc_sel[23] ^ last_vel_reg[15];
            end
            vsrl_pkg::ST_CHECK: begin
                ovf_reg <= ovf_next;
                dq_reg  <= {prod_reg[QB+DW-1:QB], prod_reg[QB-1:0]};
                cnt_reg <= '0;
            end
            vsrl_pkg::ST_DIV: begin
                dq_reg  <= dq_next;
                cnt_reg <= cnt_reg + CW'(1);
            end
            vsrl_pkg::ST_LIMIT: begin
                if (pass_reg) begin
                    hi_reg <= lim_val;
                end else begin
                    lo_reg <= lim_val;
                end
                pass_reg <= 1'b1;
            end
            vsrl_pkg::ST_STEP: begin
                vsum_reg <= vsum_next;
            end
            vsrl_pkg::ST_CLAMP: begin
                if (slot_free) begin
                    out_vel_reg    <= vclamped[15:0];
                    out_primed_reg <= 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule
